// ----- design/csgsdf_pkg.sv -----
// ----------------------------------------------------------------------------
// csgsdf_pkg
// types, codes and constants shared by the sdf edit pipeline
// ----------------------------------------------------------------------------
package csgsdf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int CELL_W      = 23;
  localparam int PADDR_W     = 3;
  localparam int LEN_STAGES  = 32;

  localparam logic [CELL_W-1:0] CELL_SIZE_RST = CELL_W'(1 << FRAC_BITS);

  // edit codes
  localparam logic [2:0] MODE_SPH_SUB   = 3'd0;
  localparam logic [2:0] MODE_SPH_ADD   = 3'd1;
  localparam logic [2:0] MODE_SPH_PAINT = 3'd2;
  localparam logic [2:0] MODE_BOX_SUB   = 3'd3;

  // register index
  localparam logic [0:0] REG_CELL_SIZE = 1'b0;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] sdf_in;
    logic [15:0]        material_in;
    logic signed [31:0] op_x;
    logic signed [31:0] op_y;
    logic signed [31:0] op_z;
    logic signed [31:0] op_radius;
    logic [15:0]        op_material;
    logic [29:0]        box_extent;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sdf_out;
    logic [15:0]        material_out;
  } out_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] sdf;
    logic [15:0]        mat;
    logic [15:0]        opmat;
    logic signed [31:0] radius;
    logic               far;
    logic signed [36:0] qneg;
  } side_t;

endpackage

// ----- design/csg_sdf_edit_apply.sv -----
// ----------------------------------------------------------------------------
// csg_sdf_edit_apply
// csg edit of one signed-distance sample against a sphere or a cell box
//
//   port group   dir     role
//   in_*         in      sample and edit operation, valid/ready
//   out_*        out     edited distance and material, valid/ready
//   p*           in/out  apb register port, cell_size at address 0
//
// one transaction per cycle while the output is taken
// the 32-stage square root gives one result bit per stage
// whole pipeline advances together; it holds when the output is not taken
// rst is synchronous; clears valid bits and sets cell_size to 1.0
// ----------------------------------------------------------------------------
module csg_sdf_edit_apply import csgsdf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic              en;
  logic [CELL_W-1:0] cell_size;
  logic              reg_sel;

  logic              mag_valid;
  logic [31:0]       mag [3];
  side_t             mag_side;
  logic              len_valid;
  logic [31:0]       len;
  logic              len_ovf;
  side_t             len_side;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign pready   = 1'b1;
  assign reg_sel  = (paddr[PADDR_W-1] == REG_CELL_SIZE);
  assign prdata   = reg_sel ? 32'(cell_size) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CELL_SIZE_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      cell_size <= pwdata[CELL_W-1:0];
    end
  end

  csgsdf_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cell_size (cell_size),
    .mag_valid (mag_valid),
    .mag       (mag),
    .side      (mag_side)
  );

  csgsdf_len u_len (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .mag_valid (mag_valid),
    .mag       (mag),
    .mag_side  (mag_side),
    .len_valid (len_valid),
    .len       (len),
    .len_ovf   (len_ovf),
    .len_side  (len_side)
  );

  csgsdf_apply u_apply (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .len_valid (len_valid),
    .len       (len),
    .len_ovf   (len_ovf),
    .len_side  (len_side),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && reg_sel |=> cell_size == $past(pwdata[CELL_W-1:0]))
    else $error("cell_size write lost");

  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

// ----- design/csgsdf_prep.sv -----
// ----------------------------------------------------------------------------
// csgsdf_prep
// offsets, box extents and per-axis magnitudes, four register stages
// ----------------------------------------------------------------------------
module csgsdf_prep import csgsdf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  in_t               in_data,
  input  logic [CELL_W-1:0] cell_size,
  output logic              mag_valid,
  output logic [31:0]       mag [3],
  output side_t             side
);

  logic signed [31:0] pt [3];
  logic signed [31:0] opc [3];
  logic [9:0]         cnt [3];

  logic               v1, v2, v3;
  side_t              sd1, sd2, sd3;
  logic signed [32:0] dx1 [3];
  logic [32:0]        ext1 [3];
  logic [30:0]        m1;
  logic signed [34:0] dd2 [3];
  logic [33:0]        w2 [3];
  logic [31:0]        mag2 [3];
  logic [31:0]        mag3 [3];
  logic signed [36:0] q3 [3];

  logic [34:0]        ad [3];
  logic [31:0]        o4 [3];
  logic               far4;
  logic signed [36:0] qmax4;
  logic               box4;

  always_comb begin
    pt[0]  = in_data.point_x;
    pt[1]  = in_data.point_y;
    pt[2]  = in_data.point_z;
    opc[0] = in_data.op_x;
    opc[1] = in_data.op_y;
    opc[2] = in_data.op_z;
    cnt[0] = in_data.box_extent[9:0];
    cnt[1] = in_data.box_extent[19:10];
    cnt[2] = in_data.box_extent[29:20];
  end

  always_comb begin
    box4 = (sd3.mode == MODE_BOX_SUB);
    far4 = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ad[a] = dd2[a][34] ? 35'(-dd2[a]) : 35'(dd2[a]);
      o4[a] = q3[a][36] ? 32'd0 : q3[a][31:0];
      if (!q3[a][36] && (|q3[a][35:32])) begin
        far4 = 1'b1;
      end
    end
    qmax4 = q3[0];
    if (q3[1] > qmax4) begin
      qmax4 = q3[1];
    end
    if (q3[2] > qmax4) begin
      qmax4 = q3[2];
    end
    if (!qmax4[36]) begin
      qmax4 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      mag_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      mag_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1.mode   <= in_data.mode;
      sd1.sdf    <= in_data.sdf_in;
      sd1.mat    <= in_data.material_in;
      sd1.opmat  <= in_data.op_material;
      sd1.radius <= in_data.op_radius;
      sd1.far    <= 1'b0;
      sd1.qneg   <= '0;
      m1         <= in_data.op_radius[31] ? 31'd0 : in_data.op_radius[30:0];
      for (int a = 0; a < 3; a++) begin
        dx1[a]  <= 33'($signed(pt[a])) - 33'($signed(opc[a]));
        ext1[a] <= 33'(cnt[a]) * 33'(cell_size);
      end
      sd2 <= sd1;
      for (int a = 0; a < 3; a++) begin
        dd2[a]  <= 35'($signed({dx1[a], 1'b0})) - $signed({2'b00, ext1[a]});
        w2[a]   <= 34'(ext1[a]) + 34'({m1, 1'b0});
        mag2[a] <= dx1[a][32] ? 32'(-dx1[a]) : dx1[a][31:0];
      end
      sd3 <= sd2;
      for (int a = 0; a < 3; a++) begin
        q3[a]   <= $signed({2'b00, ad[a]}) - $signed({3'b000, w2[a]});
        mag3[a] <= mag2[a];
      end
      side <= '{mode: sd3.mode, sdf: sd3.sdf, mat: sd3.mat, opmat: sd3.opmat,
                radius: sd3.radius, far: box4 & far4, qneg: qmax4};
      for (int a = 0; a < 3; a++) begin
        mag[a] <= box4 ? o4[a] : mag3[a];
      end
    end
  end

endmodule

// ----- design/csgsdf_len.sv -----
// ----------------------------------------------------------------------------
// csgsdf_len
// vector length: squares, 64-bit sum with overflow flag, one root bit a stage
// ----------------------------------------------------------------------------
module csgsdf_len import csgsdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        mag_valid,
  input  logic [31:0] mag [3],
  input  side_t       mag_side,
  output logic        len_valid,
  output logic [31:0] len,
  output logic        len_ovf,
  output side_t       len_side
);

  logic        va, vb;
  side_t       sda, sdb;
  logic [63:0] sqa [3];
  logic [64:0] s01b;
  logic [63:0] sq2b;
  logic [65:0] sum;

  logic        v   [LEN_STAGES+1];
  side_t       sd  [LEN_STAGES+1];
  logic        ovf [LEN_STAGES+1];
  logic [63:0] n   [LEN_STAGES+1];
  logic [63:0] r   [LEN_STAGES+1];

  assign sum = 66'(s01b) + 66'(sq2b);

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vb   <= 1'b0;
      v[0] <= 1'b0;
    end else if (en) begin
      va   <= mag_valid;
      vb   <= va;
      v[0] <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sda <= mag_side;
      for (int a = 0; a < 3; a++) begin
        sqa[a] <= 64'(mag[a]) * 64'(mag[a]);
      end
      sdb    <= sda;
      s01b   <= 65'(sqa[0]) + 65'(sqa[1]);
      sq2b   <= sqa[2];
      sd[0]  <= sdb;
      n[0]   <= sum[63:0];
      r[0]   <= '0;
      ovf[0] <= |sum[65:64];
    end
  end

  for (genvar k = 0; k < LEN_STAGES; k++) begin : g_root
    localparam logic [63:0] BIT = 64'(1) << (2 * (LEN_STAGES - 1 - k));
    logic [63:0] trial;
    assign trial = r[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1]  <= sd[k];
        ovf[k+1] <= ovf[k];
        if (n[k] >= trial) begin
          n[k+1] <= n[k] - trial;
          r[k+1] <= (r[k] >> 1) + BIT;
        end else begin
          n[k+1] <= n[k];
          r[k+1] <= r[k] >> 1;
        end
      end
    end
  end

  assign len_valid = v[LEN_STAGES];
  assign len       = r[LEN_STAGES][31:0];
  assign len_ovf   = ovf[LEN_STAGES];
  assign len_side  = sd[LEN_STAGES];

endmodule

// ----- design/csgsdf_apply.sv -----
// ----------------------------------------------------------------------------
// csgsdf_apply
// edit distance per mode, csg compare, material update and saturation
// ----------------------------------------------------------------------------
module csgsdf_apply import csgsdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        len_valid,
  input  logic [31:0] len,
  input  logic        len_ovf,
  input  side_t       len_side,
  output logic        out_valid,
  output out_t        out_data
);

  localparam logic signed [38:0] SAT_MAX = 39'sd2147483647;
  localparam logic signed [38:0] SAT_MIN = -39'sd2147483648;

  logic [32:0]        lenf;
  logic signed [34:0] dsph;
  logic [33:0]        out2;
  logic signed [37:0] t;
  logic signed [37:0] half;
  logic signed [38:0] cand;

  logic               v1;
  side_t              sd1;
  logic signed [38:0] cand1;

  logic signed [38:0] s_in;
  logic signed [38:0] s_new;
  logic [15:0]        mat_new;

  always_comb begin
    lenf = len_ovf ? 33'h1_0000_0000 : {1'b0, len};
    dsph = $signed({2'b00, lenf}) - 35'($signed(len_side.radius));
    out2 = (len_ovf || len_side.far) ? 34'h2_0000_0000 : {2'b00, len};
    t    = $signed({4'b0000, out2}) + 38'($signed(len_side.qneg));
    half = t >>> 1;
    case (len_side.mode)
      MODE_SPH_SUB:   cand = -39'(dsph);
      MODE_SPH_ADD:   cand = 39'(dsph);
      MODE_SPH_PAINT: cand = 39'(dsph);
      MODE_BOX_SUB:   cand = -39'(half);
      default:        cand = '0;
    endcase
  end

  always_comb begin
    s_in    = 39'($signed(sd1.sdf));
    s_new   = s_in;
    mat_new = sd1.mat;
    case (sd1.mode)
      MODE_SPH_SUB, MODE_BOX_SUB: begin
        if (cand1 > s_in) begin
          s_new = cand1;
          if (cand1 > 0) begin
            mat_new = '0;
          end
        end
      end
      MODE_SPH_ADD: begin
        if (cand1 < s_in) begin
          s_new = cand1;
          if (cand1 <= 0) begin
            mat_new = sd1.opmat;
          end
        end
      end
      MODE_SPH_PAINT: begin
        if (cand1 <= 0 && s_in <= 0) begin
          mat_new = sd1.opmat;
        end
      end
      default: begin
        s_new = s_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= len_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1   <= len_side;
      cand1 <= cand;
      if (s_new > SAT_MAX) begin
        out_data.sdf_out <= 32'sh7FFF_FFFF;
      end else if (s_new < SAT_MIN) begin
        out_data.sdf_out <= 32'sh8000_0000;
      end else begin
        out_data.sdf_out <= s_new[31:0];
      end
      out_data.material_out <= mat_new;
    end
  end

endmodule

// ----- tb/tb_csg_sdf_edit_apply.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_csg_sdf_edit_apply
// Self-checking bench for the sdf edit pipeline. Random sphere and box edits,
// with points near the edit as well as anywhere in range, are streamed through
// valid/ready with random gaps on both sides. A scoreboard computes the edited
// distance and material of each accepted sample and compares them in order.
// cell_size is rewritten over the apb port between phases while the pipe is idle.
// ----------------------------------------------------------------------------
module tb_csg_sdf_edit_apply;
  import csgsdf_pkg::*;

  localparam int  WDOG_LIMIT = 5000;
  localparam int  PHASE_ITEMS = 220;
  localparam int  HOLD_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  always #4 clk = ~clk;

  csg_sdf_edit_apply dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  class edit_scoreboard;
    out_t       edits_due[$];
    longint     cell_len;
    int         errors;

    function new();
      cell_len = longint'(CELL_SIZE_RST);
      errors = 0;
    endfunction

    function bit [63:0] isqrt(bit [63:0] n);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint vec_length(longint a, longint b, longint c);
      longint    v[3];
      bit [63:0] sum;
      bit [63:0] m;
      bit [63:0] sq;
      v[0] = a; v[1] = b; v[2] = c;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m = (v[i] < 0) ? -v[i] : v[i];
        sq = m * m;
        if (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) return longint'(1) << 32;
        sum = sum + sq;
      end
      return longint'(isqrt(sum));
    endfunction

    function longint sphere_gap(longint p[3], longint c[3], longint r);
      return vec_length(p[0] - c[0], p[1] - c[1], p[2] - c[2]) - r;
    endfunction

    function longint box_gap(longint p[3], longint lo[3], longint hi[3]);
      longint q[3];
      longint o[3];
      longint qmax;
      longint d;
      longint out2;
      longint t;
      bit     far;
      qmax = 64'sh8000_0000_0000_0000;
      far = 1'b0;
      for (int a = 0; a < 3; a++) begin
        d = 2 * p[a] - (lo[a] + hi[a]);
        if (d < 0) d = -d;
        q[a] = d - (hi[a] - lo[a]);
        if (q[a] > qmax) qmax = q[a];
        if (q[a] >= (longint'(1) << 32)) far = 1'b1;
      end
      if (far) begin
        out2 = longint'(1) << 33;
      end else begin
        for (int a = 0; a < 3; a++) o[a] = (q[a] > 0) ? q[a] : 0;
        out2 = vec_length(o[0], o[1], o[2]);
        if (out2 == (longint'(1) << 32)) out2 = longint'(1) << 33;
      end
      t = out2 + ((qmax < 0) ? qmax : 0);
      return (t >= 0) ? t / 2 : -((1 - t) / 2);
    endfunction

    function out_t edit_sample(in_t d);
      longint p[3];
      longint c[3];
      longint lo[3];
      longint hi[3];
      longint s;
      longint r;
      longint n;
      longint m;
      longint cnt;
      logic [15:0] mat;
      out_t res;
      p[0] = longint'($signed(d.point_x));
      p[1] = longint'($signed(d.point_y));
      p[2] = longint'($signed(d.point_z));
      c[0] = longint'($signed(d.op_x));
      c[1] = longint'($signed(d.op_y));
      c[2] = longint'($signed(d.op_z));
      s = longint'($signed(d.sdf_in));
      r = longint'($signed(d.op_radius));
      mat = d.material_in;
      case (d.mode)
        MODE_SPH_SUB: begin
          n = -sphere_gap(p, c, r);
          if (n > s) begin
            s = n;
            if (s > 0) mat = '0;
          end
        end
        MODE_SPH_ADD: begin
          n = sphere_gap(p, c, r);
          if (n < s) begin
            s = n;
            if (s <= 0) mat = d.op_material;
          end
        end
        MODE_SPH_PAINT: begin
          n = sphere_gap(p, c, r);
          if (n <= 0 && s <= 0) mat = d.op_material;
        end
        MODE_BOX_SUB: begin
          m = (r > 0) ? r : 0;
          for (int a = 0; a < 3; a++) begin
            cnt = longint'((d.box_extent >> (10 * a)) & 30'h3FF);
            lo[a] = c[a] - m;
            hi[a] = c[a] + cnt * cell_len + m;
          end
          n = -box_gap(p, lo, hi);
          if (n > s) begin
            s = n;
            if (s > 0) mat = '0;
          end
        end
        default: ;
      endcase
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      res.sdf_out = s[31:0];
      res.material_out = mat;
      return res;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    function void note_input(in_t d);
      edits_due.push_back(edit_sample(d));
    endfunction

    task check_output(out_t got);
      out_t want;
      if (edits_due.size() == 0) begin
        report("unexpected transaction", got.sdf_out, 32'h0);
        return;
      end
      want = edits_due.pop_front();
      if (got.sdf_out !== want.sdf_out) report("sdf_out", got.sdf_out, want.sdf_out);
      if (got.material_out !== want.material_out)
        report("material_out", 32'(got.material_out), 32'(want.material_out));
    endtask
  endclass

  edit_scoreboard sb = new();
  int  outs_taken = 0;
  int  idle_cycles = 0;
  bit  hold_done = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) begin
        sb.check_output(out_data);
        outs_taken++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("FAIL csg_sdf_edit_apply");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] near(logic [31:0] v);
    return v + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
  endfunction

  function automatic in_t random_item();
    in_t d;
    int  k;
    k = $urandom_range(0, 15);
    d.mode = (k < 14) ? 3'(k % 4) : 3'($urandom_range(4, 7));
    d.op_x = pick32(); d.op_y = pick32(); d.op_z = pick32();
    if ($urandom_range(0, 3) != 0) begin
      d.point_x = near(d.op_x); d.point_y = near(d.op_y); d.point_z = near(d.op_z);
    end else begin
      d.point_x = pick32(); d.point_y = pick32(); d.point_z = pick32();
    end
    d.sdf_in = ($urandom_range(0, 2) == 0) ? pick32() :
               32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    d.op_radius = ($urandom_range(0, 3) == 0) ? pick32() : 32'($urandom_range(0, 1 << 20));
    d.material_in = 16'($urandom);
    d.op_material = 16'($urandom);
    if ($urandom_range(0, 1) == 0) d.box_extent = 30'($urandom);
    else d.box_extent = {10'($urandom_range(0, 15)), 10'($urandom_range(0, 15)),
                         10'($urandom_range(0, 15))};
    return d;
  endfunction

  function automatic in_t directed_item(int k);
    in_t d;
    d = '0;
    d.mode = 3'(k % 4);
    d.material_in = 16'h1234;
    d.op_material = 16'hFFFF;
    d.op_radius = 32'h0002_0000;
    d.box_extent = {10'd2, 10'd2, 10'd2};
    case (k / 4)
      0: ;
      1: begin
        d.point_x = 32'h8000_0000; d.point_y = 32'h8000_0000; d.point_z = 32'h8000_0000;
        d.op_x = 32'h7FFF_FFFF; d.op_y = 32'h7FFF_FFFF; d.op_z = 32'h7FFF_FFFF;
        d.sdf_in = 32'h7FFF_FFFF;
        d.box_extent = 30'h3FFF_FFFF;
      end
      2: begin
        d.op_radius = 32'hFFF0_0000;
        d.sdf_in = 32'h8000_0000;
        d.material_in = 16'h0;
      end
      3: begin
        d.box_extent = '0;
        d.point_x = 32'h0000_8000;
        d.sdf_in = 32'h0001_0000;
        d.op_radius = 32'h8000_0000;
      end
      4: begin
        d.op_radius = 32'h7FFF_FFFF;
        d.sdf_in = 32'h8000_0000;
        d.point_y = 32'h7FFF_FFFF;
      end
      default: begin
        d = random_item();
        d.mode = 3'(4 + k % 4);
      end
    endcase
    return d;
  endfunction

  task automatic send_item(in_t d);
    int g;
    g = draw_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic apb_write(logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'(REG_CELL_SIZE) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.cell_len = longint'(v & 32'h7F_FFFF);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.edits_due.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  initial begin
    int g;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    forever begin
      if (!hold_done && outs_taken >= 100) begin
        hold_done = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      g = draw_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    logic [31:0] cell_set[5];
    cell_set[0] = 32'd65536;
    cell_set[1] = 32'd1;
    cell_set[2] = 32'd4194304;
    cell_set[3] = 32'd0;
    cell_set[4] = 32'($urandom_range(1, 4194304));
    repeat (8) @(posedge clk);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) drain();
      apb_write(cell_set[ph]);
      if (ph == 0) begin
        for (int k = 0; k < 24; k++) send_item(directed_item(k));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
    end
    drain();
    if (sb.errors == 0) begin
      $display("PASS csg_sdf_edit_apply");
    end else begin
      $display("FAIL csg_sdf_edit_apply");
    end
    $finish;
  end
endmodule
